>>> hdl/packet_filter_rule_table_core_assert.svh
// Assertion macros shared by the rule table modules.
`ifndef PACKET_FILTER_RULE_TABLE_CORE_ASSERT_SVH
`define PACKET_FILTER_RULE_TABLE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PFRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfrt: same-cycle check failed");

`define PFRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfrt: next-cycle check failed");

`else

`define PFRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define PFRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/pfrt_pkg.sv
package pfrt_pkg;

  localparam int unsigned PROTO_W      = 8;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned INDEX_W      = 5;
  localparam int unsigned RULE_COUNT_W = 5;
  localparam int unsigned TOTAL_W      = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // Highest valid action code: deny is 0, allow is 1.
  localparam logic [ACTION_W-1:0] ACT_MAX = 2'd1;

  typedef struct packed {
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  src_mask;
    logic [ADDR_W-1:0]  dst;
    logic [ADDR_W-1:0]  dst_mask;
    logic               allow;
  } rule_t;

  typedef struct packed {
    logic load;
    logic add_write;
    logic set_reject;
    logic start_walk;
    logic issue;
    logic move;
    logic rm_commit;
    logic chk_done;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    add_ok;
    logic    rm_ok;
    logic    more;
    logic    data_valid;
    logic    hit;
    logic    out_free;
  } dp_status_t;

endpackage

>>> hdl/pfrt_ram.sv
module pfrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pfrt_ctrl.sv
`include "packet_filter_rule_table_core_assert.svh"

module pfrt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pfrt_pkg::dp_status_t st_i,
  output pfrt_pkg::ctrl_cmd_t  cmd_o
);
  import pfrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK_CHK,
    S_WALK_RM,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st_i.op)
          OP_ADD: begin
            cmd_o.add_write  = st_i.add_ok;
            cmd_o.set_reject = !st_i.add_ok;
            state_nxt        = S_FINISH;
          end
          OP_REMOVE: begin
            if (st_i.rm_ok) begin
              cmd_o.start_walk = 1'b1;
              state_nxt        = S_WALK_RM;
            end else begin
              cmd_o.set_reject = 1'b1;
              state_nxt        = S_FINISH;
            end
          end
          OP_CHECK: begin
            cmd_o.start_walk = 1'b1;
            state_nxt        = S_WALK_CHK;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_WALK_CHK: begin
        // stop at the first matching rule or when the table is exhausted
        if (st_i.hit || !st_i.more) begin
          cmd_o.chk_done = 1'b1;
          state_nxt      = S_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      S_WALK_RM: begin
        // shift each later rule down one slot as its read data returns
        cmd_o.move = st_i.data_valid;
        if (st_i.more) begin
          cmd_o.issue = 1'b1;
        end else begin
          cmd_o.rm_commit = 1'b1;
          state_nxt       = S_FINISH;
        end
      end
      S_FINISH: begin
        if (st_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_tready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  assign in_tready = in_tready_r;

  `PFRT_ASSERT_NOW(a_ready_only_idle, clk, rst_n, in_tready_r, state_r == S_IDLE)
  `PFRT_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_tvalid && in_tready_r, !in_tready_r)
  `PFRT_ASSERT_NOW(a_publish_free_slot, clk, rst_n, cmd_o.publish, st_i.out_free)

endmodule

>>> hdl/pfrt_dp.sv
`include "packet_filter_rule_table_core_assert.svh"

module pfrt_dp #(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [pfrt_pkg::PROTO_W-1:0]           cfg_wdata,
  input  pfrt_pkg::opcode_t                      in_op,
  input  logic [pfrt_pkg::PROTO_W-1:0]           in_proto,
  input  logic [pfrt_pkg::ADDR_W-1:0]            in_src,
  input  logic [pfrt_pkg::ADDR_W-1:0]            in_src_mask,
  input  logic [pfrt_pkg::ADDR_W-1:0]            in_dst,
  input  logic [pfrt_pkg::ADDR_W-1:0]            in_dst_mask,
  input  logic [pfrt_pkg::ACTION_W-1:0]          in_action,
  input  logic [pfrt_pkg::INDEX_W-1:0]           in_index,
  input  pfrt_pkg::ctrl_cmd_t                    cmd_i,
  output pfrt_pkg::dp_status_t                   st_o,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_status,
  output logic                                   out_verdict,
  output logic [pfrt_pkg::RULE_COUNT_W-1:0]      out_rule_count,
  output logic [pfrt_pkg::TOTAL_W-1:0]           out_accepted,
  output logic [pfrt_pkg::TOTAL_W-1:0]           out_denied
);
  import pfrt_pkg::*;

  localparam int unsigned AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CW = $clog2(MAX_RULES + 1);
  localparam int unsigned XW = (CW > INDEX_W) ? CW : INDEX_W;

  // item registers
  opcode_t               op_r;
  logic [PROTO_W-1:0]    proto_r;
  logic [ADDR_W-1:0]     src_r, src_mask_r, dst_r, dst_mask_r;
  logic [ACTION_W-1:0]   action_r;
  logic [INDEX_W-1:0]    index_r;

  logic [PROTO_W-1:0]    any_proto_r;
  logic [CW-1:0]         held_r;
  logic [TOTAL_W-1:0]    acc_r, den_r;
  logic [CW-1:0]         rd_idx_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         data_addr_r;
  logic                  reject_r;
  logic                  verdict_r;
  logic                  out_valid_r;

  // result register
  logic                  res_status_r;
  logic                  res_verdict_r;
  logic [RULE_COUNT_W-1:0] res_count_r;
  logic [TOTAL_W-1:0]    res_acc_r, res_den_r;

  logic [$bits(rule_t)-1:0] ram_rdata, ram_wdata;
  logic [AW-1:0]            ram_waddr;
  logic                     ram_we;
  rule_t                    rd_rule, new_rule;
  logic                     match;
  logic                     hit;
  logic                     verdict_now;

  assign new_rule = '{proto: proto_r, src: src_r, src_mask: src_mask_r,
                      dst: dst_r, dst_mask: dst_mask_r, allow: action_r[0]};
  assign rd_rule  = rule_t'(ram_rdata);

  assign match = ((rd_rule.proto == any_proto_r) || (rd_rule.proto == proto_r)) &&
                 (((src_r ^ rd_rule.src) & rd_rule.src_mask) == '0) &&
                 (((dst_r ^ rd_rule.dst) & rd_rule.dst_mask) == '0);
  assign hit         = rd_vld_r && match;
  assign verdict_now = hit && rd_rule.allow;

  assign ram_we    = cmd_i.add_write || cmd_i.move;
  assign ram_waddr = cmd_i.add_write ? held_r[AW-1:0] : (data_addr_r - AW'(1));
  assign ram_wdata = cmd_i.add_write ? new_rule : ram_rdata;

  pfrt_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (MAX_RULES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_o.op         = op_r;
    st_o.add_ok     = (held_r < CW'(MAX_RULES)) && (action_r <= ACT_MAX);
    st_o.rm_ok      = XW'(index_r) < XW'(held_r);
    st_o.more       = rd_idx_r < held_r;
    st_o.data_valid = rd_vld_r;
    st_o.hit        = hit;
    st_o.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_proto_r <= '0;
      held_r      <= '0;
      acc_r       <= '0;
      den_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        any_proto_r <= cfg_wdata;
      end
      if (cmd_i.add_write) begin
        held_r <= held_r + CW'(1);
      end else if (cmd_i.rm_commit) begin
        held_r <= held_r - CW'(1);
      end
      if (cmd_i.chk_done) begin
        if (verdict_now) begin
          acc_r <= acc_r + TOTAL_W'(1);
        end else begin
          den_r <= den_r + TOTAL_W'(1);
        end
      end
      rd_vld_r <= cmd_i.issue;
      if (cmd_i.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r       <= in_op;
      proto_r    <= in_proto;
      src_r      <= in_src;
      src_mask_r <= in_src_mask;
      dst_r      <= in_dst;
      dst_mask_r <= in_dst_mask;
      action_r   <= in_action;
      index_r    <= in_index;
      reject_r   <= 1'b0;
      verdict_r  <= 1'b0;
    end else begin
      if (cmd_i.set_reject) begin
        reject_r <= 1'b1;
      end
      if (cmd_i.chk_done) begin
        verdict_r <= verdict_now;
      end
    end
    if (cmd_i.start_walk) begin
      // remove starts with the rule after the one dropped
      rd_idx_r <= (op_r == OP_REMOVE) ? (CW'(index_r) + CW'(1)) : '0;
    end else if (cmd_i.issue) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end
    if (cmd_i.issue) begin
      data_addr_r <= rd_idx_r[AW-1:0];
    end
    if (cmd_i.publish) begin
      res_status_r  <= reject_r;
      res_verdict_r <= verdict_r;
      res_count_r   <= RULE_COUNT_W'(held_r);
      res_acc_r     <= acc_r;
      res_den_r     <= den_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = res_status_r;
  assign out_verdict    = res_verdict_r;
  assign out_rule_count = res_count_r;
  assign out_accepted   = res_acc_r;
  assign out_denied     = res_den_r;

  `PFRT_ASSERT_NOW(a_held_bounded, clk, rst_n, 1'b1, held_r <= CW'(MAX_RULES))
  `PFRT_ASSERT_NEXT(a_add_grows, clk, rst_n, cmd_i.add_write, held_r == $past(held_r) + CW'(1))
  `PFRT_ASSERT_NOW(a_read_in_table, clk, rst_n, rd_vld_r, CW'(data_addr_r) < held_r)

endmodule

>>> hdl/packet_filter_rule_table_core.sv
// Add, rejected item or unused opcode: DECODE, then FINISH, which publishes to out_tvalid.
// Check: DECODE, a walk reading the table RAM port one rule per cycle up to a match, FINISH.
// Remove: DECODE, a walk moving the rules after the removed index one per cycle, FINISH.
// Throughput: one item at a time; in_tready rises at the edge that registers the result,
// delayed while an unaccepted earlier result holds the output register.
// Reset: rule count, both counters and any_protocol_code clear; in_tready low during reset.
module packet_filter_rule_table_core #(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,     // any_protocol_code
  input  logic         in_tvalid,
  output logic         in_tready,
  // protocol_value[7:0], source_value[39:8], src_mask[71:40],
  // destination_value[103:72], dst_mask[135:104], rule_action[137:136],
  // rule_index[142:138], zero[143]
  input  logic [143:0] in_tdata,
  input  logic [1:0]   in_tuser,      // opcode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[0], verdict[1], rule_count[6:2], accepted_count[38:7],
  // denied_count[70:39], zero[71]
  output logic [71:0]  out_tdata
);
  import pfrt_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         st;
  logic               res_status, res_verdict;
  logic [RULE_COUNT_W-1:0] res_count;
  logic [TOTAL_W-1:0] res_acc, res_den;

  pfrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  pfrt_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_op          (opcode_t'(in_tuser)),
    .in_proto       (in_tdata[7:0]),
    .in_src         (in_tdata[39:8]),
    .in_src_mask    (in_tdata[71:40]),
    .in_dst         (in_tdata[103:72]),
    .in_dst_mask    (in_tdata[135:104]),
    .in_action      (in_tdata[137:136]),
    .in_index       (in_tdata[142:138]),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (res_status),
    .out_verdict    (res_verdict),
    .out_rule_count (res_count),
    .out_accepted   (res_acc),
    .out_denied     (res_den)
  );

  assign out_tdata = {1'b0, res_den, res_acc, res_count, res_verdict, res_status};

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfrt_pkg::*;

  localparam int unsigned MAX_RULES       = 16;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          STALL_LIMIT     = 2000;
  localparam int          PHASE_ITEMS     = 100;
  localparam int          TAIL_CYCLES     = 30;

  typedef struct packed {
    opcode_t     op;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] smask;
    logic [31:0] dst;
    logic [31:0] dmask;
    logic [1:0]  act;
    logic [4:0]  idx;
  } item_t;

  typedef struct packed {
    logic        status;
    logic        verdict;
    logic [4:0]  count;
    logic [31:0] acc;
    logic [31:0] den;
  } result_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  typedef enum int {RX_READY, RX_MOSTLY, RX_TOGGLE, RX_RANDOM} rx_mode_t;

  logic         clk;
  logic         rst_n     = 1'b0;
  logic         cfg_we    = 1'b0;
  logic [7:0]   cfg_wdata = 8'd0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata  = '0;
  logic [1:0]   in_tuser  = OP_NONE;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;

  // filter state as the block should hold it
  rule_t        rule_table [MAX_RULES];
  int unsigned  held_rules;
  logic [31:0]  allowed_total;
  logic [31:0]  denied_total;
  logic [7:0]   wildcard_proto;

  result_t      expected_results [$];
  int           mismatches;
  int           burst_left;
  bit           hold_off_req;
  int           n_items, n_checks, n_allowed, n_rejected, n_settings;

  packet_filter_rule_table_core #(.MAX_RULES(MAX_RULES)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t filter_step(input item_t it);
    result_t r;
    bit      hit;
    r = '0;
    hit = 1'b0;
    case (it.op)
      OP_ADD: begin
        if (held_rules >= MAX_RULES || it.act > ACT_MAX) begin
          r.status = 1'b1;
        end else begin
          rule_table[held_rules] = '{proto: it.proto, src: it.src, src_mask: it.smask,
                                     dst: it.dst, dst_mask: it.dmask, allow: it.act[0]};
          held_rules++;
        end
      end
      OP_REMOVE: begin
        if (it.idx >= held_rules) begin
          r.status = 1'b1;
        end else begin
          // close the gap left by the removed rule
          for (int i = it.idx + 1; i < held_rules; i++) rule_table[i-1] = rule_table[i];
          held_rules--;
        end
      end
      OP_CHECK: begin
        for (int i = 0; i < held_rules && !hit; i++) begin
          if ((rule_table[i].proto == wildcard_proto || rule_table[i].proto == it.proto) &&
              ((it.src ^ rule_table[i].src) & rule_table[i].src_mask) == 32'd0 &&
              ((it.dst ^ rule_table[i].dst) & rule_table[i].dst_mask) == 32'd0) begin
            hit = 1'b1;
            r.verdict = rule_table[i].allow;
          end
        end
        if (r.verdict) allowed_total++;
        else denied_total++;
      end
      default: ;
    endcase
    r.count = held_rules[4:0];
    r.acc   = allowed_total;
    r.den   = denied_total;
    return r;
  endfunction

  function automatic item_t mk(input opcode_t op, input logic [7:0] proto,
                               input logic [31:0] src, input logic [31:0] smask,
                               input logic [31:0] dst, input logic [31:0] dmask,
                               input logic [1:0] act, input logic [4:0] idx);
    return '{op, proto, src, smask, dst, dmask, act, idx};
  endfunction

  function automatic result_t res(input logic status, input logic verdict,
                                  input logic [4:0] count, input logic [31:0] acc,
                                  input logic [31:0] den);
    return '{status, verdict, count, acc, den};
  endfunction

  function automatic item_t random_fields(input opcode_t op);
    return mk(op, 8'($urandom_range(0, 255)), $urandom, $urandom, $urandom, $urandom,
              2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
  endfunction

  function automatic logic [31:0] prefix_mask();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'hFFFF_FFFF << (32 - $urandom_range(0, 32));
  endfunction

  function automatic item_t random_rule(input bit valid_only);
    item_t it;
    it = random_fields(OP_ADD);
    case ($urandom_range(0, 4))
      0: it.proto = wildcard_proto;
      1: it.proto = 8'd6;
      2: it.proto = 8'd17;
      3: it.proto = 8'd1;
      default: ;
    endcase
    it.smask = prefix_mask();
    it.dmask = prefix_mask();
    if (valid_only || $urandom_range(0, 9) != 0) it.act = 2'($urandom_range(0, 1));
    return it;
  endfunction

  // Offer one item, predict its result at the transfer.
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t r;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, it.idx, it.act, it.dmask, it.dst, it.smask, it.src, it.proto};
    in_tuser  <= it.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = filter_step(it);
    expected_results.push_back(typed ? want : r);
    burst_left--;
    n_items++;
    if (it.op == OP_CHECK) n_checks++;
    if (r.verdict) n_allowed++;
    if (r.status) n_rejected++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_wildcard(input logic [7:0] code);
    drain_results();
    cfg_wdata <= code;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    wildcard_proto = code;
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = out_tdata[0];
      got.verdict = out_tdata[1];
      got.count   = out_tdata[6:2];
      got.acc     = out_tdata[38:7];
      got.den     = out_tdata[70:39];
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: 0x%0h", out_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("verdict", 32'(want.verdict), 32'(got.verdict));
        check_field("rule_count", 32'(want.count), 32'(got.count));
        check_field("accepted_count", want.acc, got.acc);
        check_field("denied_count", want.den, got.den);
      end
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int       run;
    forever begin
      if (hold_off_req) begin
        // hold off long enough for the block to back up its input
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      run  = $urandom_range(4, 40);
      repeat (run) begin
        case (mode)
          RX_READY:  out_tready <= 1'b1;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_tready <= ~out_tready;
          default:   out_tready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    row_t        rows [$];
    logic [7:0]  wild_codes [4];
    item_t       it;
    rule_t       r;
    int          pick;

    held_rules     = 0;
    allowed_total  = '0;
    denied_total   = '0;
    wildcard_proto = 8'd0;
    mismatches     = 0;
    burst_left     = 0;
    hold_off_req   = 1'b0;
    n_items = 0; n_checks = 0; n_allowed = 0; n_rejected = 0; n_settings = 0;

    // empty table, rejects and a first rule
    rows.push_back('{mk(OP_CHECK, 8'd6, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd0), 1'b1,
                     res(1'b0, 1'b0, 5'd0, 32'd0, 32'd1)});
    rows.push_back('{mk(OP_REMOVE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd0), 1'b1,
                     res(1'b1, 1'b0, 5'd0, 32'd0, 32'd1)});
    rows.push_back('{mk(OP_ADD, 8'd17, 32'h0A00_0000, 32'hFF00_0000, 32'd0, 32'd0, 2'd2,
                        5'd0), 1'b1, res(1'b1, 1'b0, 5'd0, 32'd0, 32'd1)});
    rows.push_back('{mk(OP_ADD, 8'hFF, '1, '1, '1, '1, 2'd3, 5'd31), 1'b1,
                     res(1'b1, 1'b0, 5'd0, 32'd0, 32'd1)});
    rows.push_back('{mk(OP_ADD, 8'd17, 32'h0A00_0000, 32'hFF00_0000, 32'd0, 32'd0, 2'd1,
                        5'd0), 1'b1, res(1'b0, 1'b0, 5'd1, 32'd0, 32'd1)});
    rows.push_back('{mk(OP_CHECK, 8'd17, 32'h0A01_0203, 32'd0, '1, 32'd0, 2'd0, 5'd0), 1'b1,
                     res(1'b0, 1'b1, 5'd1, 32'd1, 32'd1)});
    // protocol miss, source miss, then a wildcard catch-all deny
    rows.push_back('{mk(OP_CHECK, 8'd6, 32'h0A01_0203, 32'd0, 32'd0, 32'd0, 2'd0, 5'd0),
                     1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 8'd17, 32'h0B00_0000, 32'd0, 32'd0, 32'd0, 2'd0, 5'd0),
                     1'b0, '0});
    rows.push_back('{mk(OP_ADD, 8'd0, '1, 32'd0, 32'h1234_5678, 32'd0, 2'd0, 5'd0), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 8'd6, 32'h0A01_0203, 32'd0, 32'd0, 32'd0, 2'd0, 5'd0),
                     1'b0, '0});
    rows.push_back('{mk(OP_ADD, 8'hFF, '1, '1, '1, '1, 2'd1, 5'd0), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 8'hFF, '1, '1, '1, '1, 2'd3, 5'd31), 1'b0, '0});
    rows.push_back('{mk(OP_NONE, 8'hFF, '1, '1, '1, '1, 2'd3, 5'd31), 1'b0, '0});
    // removes out of range, on the boundary, in the middle and at the end
    rows.push_back('{mk(OP_REMOVE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd31), 1'b0, '0});
    rows.push_back('{mk(OP_REMOVE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd3), 1'b0, '0});
    rows.push_back('{mk(OP_REMOVE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd1), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 8'hFF, '1, 32'd0, '1, 32'd0, 2'd0, 5'd0), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 8'hFF, 32'hFFFF_FFFE, 32'd0, '1, 32'd0, 2'd0, 5'd0),
                     1'b0, '0});
    rows.push_back('{mk(OP_REMOVE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd1), 1'b0, '0});
    rows.push_back('{mk(OP_ADD, 8'd6, 32'd0, 32'd0, 32'hC0A8_0000, 32'hFFFF_0000, 2'd0,
                        5'd0), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 8'd6, 32'h0A00_0001, 32'd0, 32'hC0A8_0101, 32'd0, 2'd0,
                        5'd0), 1'b0, '0});
    rows.push_back('{mk(OP_REMOVE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd0), 1'b0, '0});
    rows.push_back('{mk(OP_REMOVE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd0), 1'b0, '0});
    rows.push_back('{mk(OP_CHECK, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 5'd0), 1'b0, '0});

    wild_codes[0] = 8'hFF;
    wild_codes[1] = 8'($urandom_range(1, 254));
    wild_codes[2] = 8'h00;
    wild_codes[3] = 8'd6;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);

    for (int p = 0; p < 4; p++) begin
      set_wildcard(wild_codes[p]);
      // fill the table, then one more add that must bounce off the full table
      while (held_rules < MAX_RULES) send_item(random_rule(1'b1), 1'b0, '0);
      send_item(random_rule(1'b1), 1'b0, '0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 30) hold_off_req = 1'b1;
        if (p == 2 && n == 50) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 28 || (held_rules < 2 && pick < 60)) begin
          it = random_rule(1'b0);
        end else if (pick < 43) begin
          it = random_fields(OP_REMOVE);
          if (held_rules == 0 || $urandom_range(0, 7) == 0)
            it.idx = 5'($urandom_range(held_rules, 31));
          else
            it.idx = 5'($urandom_range(0, held_rules - 1));
        end else if (pick < 90) begin
          it = random_fields(OP_CHECK);
          if (held_rules > 0 && $urandom_range(0, 9) < 7) begin
            // aim the packet at a stored rule, with a stray bit now and then
            r = rule_table[$urandom_range(0, held_rules - 1)];
            if (r.proto != wildcard_proto || $urandom_range(0, 1) == 0) it.proto = r.proto;
            it.src = (r.src & r.src_mask) | (it.src & ~r.src_mask);
            it.dst = (r.dst & r.dst_mask) | (it.dst & ~r.dst_mask);
            if ($urandom_range(0, 4) == 0) it.src ^= 32'd1 << $urandom_range(0, 31);
            if ($urandom_range(0, 4) == 0) it.dst ^= 32'd1 << $urandom_range(0, 31);
          end
        end else begin
          it = random_fields(opcode_t'($urandom_range(0, 3)));
        end
        send_item(it, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d checks (%0d allowed), %0d rejected edits,",
             n_items, n_checks, n_allowed, n_rejected);
    $display("full and empty table, %0d wildcard protocol settings, long output stall",
             n_settings);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/pfrt_pkg.sv
hdl/pfrt_ram.sv
hdl/pfrt_ctrl.sv
hdl/pfrt_dp.sv
hdl/packet_filter_rule_table_core.sv
verif/tb.sv
